// File: hw/rtl/acmrs_pkg.sv
// ----------------------------------------------------------------------------
// acmrs_pkg
// Shared types, codes and helper functions for the ant-colony route select.
// ----------------------------------------------------------------------------
package acmrs_pkg;

    // mesh size, nodes per side
    localparam int unsigned MESH_DIM = 8;

    // last coordinate on the mesh, with room for the largest mesh size
    localparam logic [8:0] EDGE_MAX = 9'(MESH_DIM - 1);

    // port codes
    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } t_dir;

    // configuration register indexes
    localparam logic [1:0] CFG_CURRENT_X   = 2'd0;
    localparam logic [1:0] CFG_CURRENT_Y   = 2'd1;
    localparam logic [1:0] CFG_TOWARD_GAIN = 2'd2;

    // reset values
    localparam logic [2:0] RST_COORD = 3'd4;
    localparam logic [3:0] RST_GAIN  = 4'd4;
    localparam logic [8:0] RST_PHER  = 9'd128;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WEIGH = 2'd1,
        ST_PICK  = 2'd2
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // item accepted: capture fields, update pheromone
        logic weigh;  // compute and register port weights
        logic pick;   // roulette pick into the output register
    } t_dp_cmd;

    // floor(v * 100 / 256) by shift and add, at most 199
    function automatic logic [7:0] level_factor(input logic [8:0] v);
        logic [15:0] prod;
        prod = {1'b0, v, 6'b0} + {2'b0, v, 5'b0} + {5'b0, v, 2'b0};
        return prod[15:8];
    endfunction

endpackage

// File: hw/rtl/acmrs_ctrl.sv
// ----------------------------------------------------------------------------
// acmrs_ctrl
// Sequencer for one packet decision: accept, weigh, pick, and the output
// valid flag of the result register.
// ----------------------------------------------------------------------------
module acmrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output acmrs_pkg::t_dp_cmd o_cmd
);

    acmrs_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              out_load;
    logic              in_ready;
    logic              in_acc;

    // state and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acmrs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        out_load = (r_state == acmrs_pkg::ST_PICK) && (!r_out_valid || !i_out_stall);
        in_ready = (r_state == acmrs_pkg::ST_IDLE) || out_load;
        in_acc   = i_in_valid && in_ready;
        n_state  = r_state;
        unique case (r_state)
            acmrs_pkg::ST_IDLE: begin
                if (in_acc) n_state = acmrs_pkg::ST_WEIGH;
            end
            acmrs_pkg::ST_WEIGH: begin
                n_state = acmrs_pkg::ST_PICK;
            end
            acmrs_pkg::ST_PICK: begin
                if (out_load) n_state = in_acc ? acmrs_pkg::ST_WEIGH : acmrs_pkg::ST_IDLE;
            end
            default: begin
                n_state = acmrs_pkg::ST_IDLE;
            end
        endcase

        // result stays until taken
        if (out_load)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;

        o_cmd.load  = in_acc;
        o_cmd.weigh = (r_state == acmrs_pkg::ST_WEIGH);
        o_cmd.pick  = out_load;
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_acc_to_weigh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == acmrs_pkg::ST_WEIGH)
        else $error("accepted item did not start weighing");

    a_weigh_to_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == acmrs_pkg::ST_WEIGH |=> r_state == acmrs_pkg::ST_PICK)
        else $error("weigh step not followed by pick");

    a_pick_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("picked result not presented");

    a_pick_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acmrs_pkg::ST_PICK && r_out_valid && i_out_stall)
        |=> (r_state == acmrs_pkg::ST_PICK && r_out_valid))
        else $error("pick did not wait for a full output register");
`endif

endmodule

// File: hw/rtl/acmrs_dp.sv
// ----------------------------------------------------------------------------
// acmrs_dp
// Datapath: configuration, port pheromone, weight computation and
// roulette selection into the result register.
// ----------------------------------------------------------------------------
module acmrs_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acmrs_pkg::t_dp_cmd i_cmd,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    input  logic [1:0]         i_arrival_dir,
    input  logic [8:0]         i_pheromone,
    input  logic [2:0]         i_dest_x,
    input  logic [2:0]         i_dest_y,
    input  logic [15:0]        i_random_draw,
    output logic [1:0]         o_out_dir,
    output logic               o_route_found
);

    logic [2:0]  r_cur_x;
    logic [2:0]  r_cur_y;
    logic [3:0]  r_gain;
    logic [8:0]  r_ph [4];
    logic [1:0]  r_arr;
    logic [2:0]  r_dx;
    logic [2:0]  r_dy;
    logic [15:0] r_rnd;
    logic [11:0] r_w [4];
    logic [13:0] r_sum;
    logic [1:0]  r_dir;
    logic        r_found;

    logic [3:0]  fac [4];
    logic [11:0] w [4];
    logic [13:0] sum;
    logic [29:0] prod;
    logic [13:0] thr;
    logic [13:0] run [4];
    logic [1:0]  n_dir;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= acmrs_pkg::RST_COORD;
            r_cur_y <= acmrs_pkg::RST_COORD;
            r_gain  <= acmrs_pkg::RST_GAIN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acmrs_pkg::CFG_CURRENT_X:   r_cur_x <= i_cfg_data[2:0];
                acmrs_pkg::CFG_CURRENT_Y:   r_cur_y <= i_cfg_data[2:0];
                acmrs_pkg::CFG_TOWARD_GAIN: r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pheromone update of the arrival port on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_ph[i] <= acmrs_pkg::RST_PHER;
        end else if (i_cmd.load) begin
            for (int i = 0; i < 4; i++) begin
                if (i_arrival_dir == 2'(i)) begin
                    r_ph[i] <= 9'(({1'b0, r_ph[i]} + {1'b0, i_pheromone}) >> 1);
                end
            end
        end
    end

    // captured packet fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_arr <= i_arrival_dir;
            r_dx  <= i_dest_x;
            r_dy  <= i_dest_y;
            r_rnd <= i_random_draw;
        end
    end

    // per-port factor: gain toward destination, zero for arrival and edges
    always_comb begin
        for (int i = 0; i < 4; i++) fac[i] = 4'd1;
        if (r_dx > r_cur_x)
            fac[acmrs_pkg::DIR_EAST] = r_gain;
        else if (r_dx < r_cur_x)
            fac[acmrs_pkg::DIR_WEST] = r_gain;
        if (r_dy > r_cur_y)
            fac[acmrs_pkg::DIR_SOUTH] = r_gain;
        else if (r_dy < r_cur_y)
            fac[acmrs_pkg::DIR_NORTH] = r_gain;
        fac[r_arr] = 4'd0;
        if (r_cur_x == 3'd0)
            fac[acmrs_pkg::DIR_WEST] = 4'd0;
        if ({6'b0, r_cur_x} >= acmrs_pkg::EDGE_MAX)
            fac[acmrs_pkg::DIR_EAST] = 4'd0;
        if (r_cur_y == 3'd0)
            fac[acmrs_pkg::DIR_NORTH] = 4'd0;
        if ({6'b0, r_cur_y} >= acmrs_pkg::EDGE_MAX)
            fac[acmrs_pkg::DIR_SOUTH] = 4'd0;
    end

    // weights and their sum
    always_comb begin
        sum = '0;
        for (int i = 0; i < 4; i++) begin
            w[i] = 12'(fac[i]) * 12'(acmrs_pkg::level_factor(r_ph[i]));
            sum  = sum + {2'b0, w[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.weigh) begin
            r_w   <= w;
            r_sum <= sum;
        end
    end

    // roulette: first port whose running sum exceeds the threshold
    always_comb begin
        prod   = 30'(r_rnd) * 30'(r_sum);
        thr    = prod[29:16];
        run[0] = {2'b0, r_w[0]};
        for (int i = 1; i < 4; i++) run[i] = run[i-1] + {2'b0, r_w[i]};
        n_dir = acmrs_pkg::DIR_NORTH;
        for (int i = 3; i >= 0; i--) begin
            if (run[i] > thr) n_dir = 2'(i);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_dir   <= n_dir;
            r_found <= (r_sum != 14'd0);
        end
    end

    assign o_out_dir     = r_dir;
    assign o_route_found = r_found;

endmodule

// File: hw/rtl/ant_colony_mesh_route_select.sv
// ----------------------------------------------------------------------------
// ant_colony_mesh_route_select
// Output-port choice of a 2D-mesh router weighted by per-port pheromone.
// ----------------------------------------------------------------------------
// an accepted item is weighed (factor times level) into registers, then
// picked (threshold multiply) into the output register; the pick waits
// while that register is full and stalled, and can take the next item
// reset: node at (4,4), gain 4, every port pheromone 128; no clearing pass
module ant_colony_mesh_route_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // packet input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_arrival_dir,
    input  logic [8:0]  i_pheromone,
    input  logic [2:0]  i_dest_x,
    input  logic [2:0]  i_dest_y,
    input  logic [15:0] i_random_draw,
    // route result
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_dir,
    output logic        o_route_found
);

    acmrs_pkg::t_dp_cmd cmd;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    acmrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    acmrs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_arrival_dir (i_arrival_dir),
        .i_pheromone   (i_pheromone),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .i_random_draw (i_random_draw),
        .o_out_dir     (o_out_dir),
        .o_route_found (o_route_found)
    );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the ant-colony route select of one mesh router. A directed table
// covers reset values, field extremes, mesh edges, zero gain, an empty wheel
// and an ignored register index. Random packets then run under several node
// settings. Every route that comes out is compared with a table expectation
// or with a local model of the pheromone store and the roulette pick. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASE_ITEMS  = 75;
    localparam int          PHASE_COUNT  = 6;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    // short names for port and register codes
    localparam acmrs_pkg::t_dir NORTH    = acmrs_pkg::DIR_NORTH;
    localparam acmrs_pkg::t_dir EAST     = acmrs_pkg::DIR_EAST;
    localparam acmrs_pkg::t_dir SOUTH    = acmrs_pkg::DIR_SOUTH;
    localparam acmrs_pkg::t_dir WEST     = acmrs_pkg::DIR_WEST;
    localparam logic [1:0]      CFG_X    = acmrs_pkg::CFG_CURRENT_X;
    localparam logic [1:0]      CFG_Y    = acmrs_pkg::CFG_CURRENT_Y;
    localparam logic [1:0]      CFG_GAIN = acmrs_pkg::CFG_TOWARD_GAIN;

    // one route decision
    typedef struct packed {
        acmrs_pkg::t_dir dir;
        logic            found;
    } t_route;

    // one row of the directed table: a register write or a packet
    typedef struct {
        bit              is_cfg;
        logic [1:0]      cfg_idx;
        logic [3:0]      cfg_val;
        acmrs_pkg::t_dir arr;
        logic [8:0]      pher;
        logic [2:0]      dx;
        logic [2:0]      dy;
        logic [15:0]     draw;
        bit              typed;
        t_route          want;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [3:0]  i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_arrival_dir = '0;
    logic [8:0]  i_pheromone   = '0;
    logic [2:0]  i_dest_x      = '0;
    logic [2:0]  i_dest_y      = '0;
    logic [15:0] i_random_draw = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_out_dir;
    logic        o_route_found;

    ant_colony_mesh_route_select dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_arrival_dir (i_arrival_dir),
        .i_pheromone   (i_pheromone),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .i_random_draw (i_random_draw),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_dir     (o_out_dir),
        .o_route_found (o_route_found)
    );

    // model state: node position, gain and per-port pheromone
    logic [2:0] node_x;
    logic [2:0] node_y;
    logic [3:0] gain_val;
    logic [8:0] port_pher [4];

    t_route     route_q [$];
    t_route     head;
    t_row       dir_tab [$];
    int         errors      = 0;
    int         routes_seen = 0;
    int         items_sent  = 0;
    int         cfg_writes  = 0;
    int         burst_left  = 0;
    int         cycles      = 0;
    int         stall_run   = 0;
    logic [1:0] stall_mode  = 2'd0;
    logic [3:0] stall_tick  = 4'd0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // update the arrival port pheromone, weigh the ports, spin the wheel
    function automatic t_route choose_port(acmrs_pkg::t_dir arr, logic [8:0] ph,
                                           logic [2:0] dx, logic [2:0] dy,
                                           logic [15:0] draw);
        logic [3:0]  fac [4];
        logic [15:0] scaled;
        logic [11:0] wt [4];
        logic [13:0] total;
        logic [13:0] run;
        logic [29:0] prod;
        t_route      res;
        int          i;
        port_pher[arr] = 9'((10'(port_pher[arr]) + 10'(ph)) >> 1);
        for (i = 0; i < 4; i++)
            fac[i] = 4'd1;
        if (dx > node_x)
            fac[EAST] = gain_val;
        else if (dx < node_x)
            fac[WEST] = gain_val;
        if (dy > node_y)
            fac[SOUTH] = gain_val;
        else if (dy < node_y)
            fac[NORTH] = gain_val;
        fac[arr] = 4'd0;
        // ports that would leave the mesh
        if (node_x == 3'd0)
            fac[WEST] = 4'd0;
        if (int'(node_x) >= int'(acmrs_pkg::MESH_DIM) - 1)
            fac[EAST] = 4'd0;
        if (node_y == 3'd0)
            fac[NORTH] = 4'd0;
        if (int'(node_y) >= int'(acmrs_pkg::MESH_DIM) - 1)
            fac[SOUTH] = 4'd0;
        total = '0;
        for (i = 0; i < 4; i++) begin
            scaled = 16'(port_pher[i]) * 16'd100;
            wt[i]  = 12'(fac[i]) * 12'(scaled[15:8]);
            total  = total + 14'(wt[i]);
        end
        res.dir   = NORTH;
        res.found = 1'b0;
        // first port whose running sum passes the threshold
        if (total != '0) begin
            prod = 30'(draw) * 30'(total);
            run  = '0;
            for (i = 0; i < 4 && !res.found; i++) begin
                run = run + 14'(wt[i]);
                if (run > prod[29:16]) begin
                    res.dir   = acmrs_pkg::t_dir'(i[1:0]);
                    res.found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_row pkt_row(acmrs_pkg::t_dir a, logic [8:0] p, logic [2:0] x,
                                     logic [2:0] y, logic [15:0] r, bit k,
                                     acmrs_pkg::t_dir ed, logic ef);
        t_row row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.arr     = a;
        row.pher    = p;
        row.dx      = x;
        row.dy      = y;
        row.draw    = r;
        row.typed   = k;
        row.want    = '{dir: ed, found: ef};
        return row;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [3:0] val);
        t_row row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.arr     = NORTH;
        row.pher    = '0;
        row.dx      = '0;
        row.dy      = '0;
        row.draw    = '0;
        row.typed   = 1'b0;
        row.want    = '{dir: NORTH, found: 1'b0};
        return row;
    endfunction

    // one packet through the input handshake, then the sender's burst/gap pattern
    task automatic send_packet(acmrs_pkg::t_dir arr, logic [8:0] ph, logic [2:0] dx,
                               logic [2:0] dy, logic [15:0] draw, bit typed,
                               t_route want);
        t_route calc;
        int     gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_arrival_dir <= arr;
        i_pheromone   <= ph;
        i_dest_x      <= dx;
        i_dest_y      <= dy;
        i_random_draw <= draw;
        do @(posedge i_clk); while (o_in_stall);
        calc = choose_port(arr, ph, dx, dy, draw);
        route_q.push_back(typed ? want : calc);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // stop sending and let every pending route come out
    task automatic drain_routes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left  = 0;
        while (route_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_X:    node_x   = val[2:0];
            CFG_Y:    node_y   = val[2:0];
            CFG_GAIN: gain_val = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern: free, light random, periodic, heavy random
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 4'd1;
        if (stall_run == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_run  <= $urandom_range(10, 60);
        end else begin
            stall_run  <= stall_run - 1;
        end
        case (stall_mode)
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(0, 99) < 30);
            2'd2:    i_out_stall <= (stall_tick[1:0] == 2'b00);
            default: i_out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // compare each route taken with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_q.size() == 0) begin
                $display("%0t: route with nothing expected: out_dir %0d route_found %0b",
                         $time, o_out_dir, o_route_found);
                errors++;
            end else begin
                head = route_q.pop_front();
                routes_seen++;
                if (o_out_dir !== head.dir) begin
                    $display("%0t: out_dir expected %0d actual %0d",
                             $time, head.dir, o_out_dir);
                    errors++;
                end
                if (o_route_found !== head.found) begin
                    $display("%0t: route_found expected %0b actual %0b",
                             $time, head.found, o_route_found);
                    errors++;
                end
            end
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d routes pending", $time, route_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        acmrs_pkg::t_dir arr;
        logic [8:0]      ph;
        logic [15:0]     draw;
        logic [3:0]      nx;
        logic [3:0]      ny;
        logic [3:0]      ng;
        int              sel;
        int              r;
        int              p;
        node_x   = acmrs_pkg::RST_COORD;
        node_y   = acmrs_pkg::RST_COORD;
        gain_val = acmrs_pkg::RST_GAIN;
        for (r = 0; r < 4; r++)
            port_pher[r] = acmrs_pkg::RST_PHER;

        // directed table: reset values first, then edges, gains and odd writes
        dir_tab.push_back(pkt_row(NORTH, 9'd128, 3'd4, 3'd4, 16'h0000, 1, EAST, 1'b1));
        dir_tab.push_back(pkt_row(NORTH, 9'd128, 3'd4, 3'd4, 16'hFFFF, 1, WEST, 1'b1));
        dir_tab.push_back(pkt_row(EAST,  9'd511, 3'd7, 3'd7, 16'h8000, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(SOUTH, 9'd0,   3'd0, 3'd0, 16'h1234, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(WEST,  9'd256, 3'd0, 3'd7, 16'hFFFF, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(WEST,  9'd0,   3'd7, 3'd0, 16'h0000, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_GAIN, 4'd15));
        dir_tab.push_back(pkt_row(NORTH, 9'd300, 3'd7, 3'd7, 16'h9C3A, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(EAST,  9'd256, 3'd0, 3'd0, 16'hFFFF, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_GAIN, 4'd0));
        dir_tab.push_back(pkt_row(SOUTH, 9'd128, 3'd7, 3'd7, 16'h4000, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_X, 4'd0));
        dir_tab.push_back(cfg_row(CFG_Y, 4'd0));
        // corner node, zero gain, entering from east: the wheel is empty
        dir_tab.push_back(pkt_row(EAST,  9'd128, 3'd0, 3'd7, 16'h0000, 1, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(NORTH, 9'd511, 3'd3, 3'd3, 16'hFFFF, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_GAIN, 4'd15));
        dir_tab.push_back(pkt_row(SOUTH, 9'd256, 3'd7, 3'd7, 16'h0001, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_X, 4'd7));
        dir_tab.push_back(cfg_row(CFG_Y, 4'd15));
        dir_tab.push_back(pkt_row(NORTH, 9'd128, 3'd0, 3'd0, 16'h7FFF, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(WEST,  9'd511, 3'd7, 3'd7, 16'hFFFF, 0, NORTH, 1'b0));
        // unused register index: nothing may change
        dir_tab.push_back(cfg_row(CFG_UNUSED, 4'd15));
        dir_tab.push_back(pkt_row(EAST,  9'd200, 3'd3, 3'd7, 16'hC000, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_Y, 4'd0));
        dir_tab.push_back(pkt_row(SOUTH, 9'd0,   3'd0, 3'd7, 16'h0000, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_X, 4'd0));
        dir_tab.push_back(cfg_row(CFG_Y, 4'd7));
        dir_tab.push_back(pkt_row(NORTH, 9'd256, 3'd7, 3'd0, 16'hFFFF, 0, NORTH, 1'b0));
        dir_tab.push_back(cfg_row(CFG_X, 4'd3));
        dir_tab.push_back(cfg_row(CFG_Y, 4'd5));
        dir_tab.push_back(cfg_row(CFG_GAIN, 4'd1));
        dir_tab.push_back(pkt_row(WEST,  9'd1,   3'd2, 3'd6, 16'hAAAA, 0, NORTH, 1'b0));
        dir_tab.push_back(pkt_row(EAST,  9'h155, 3'd5, 3'd2, 16'h5555, 0, NORTH, 1'b0));

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                drain_routes();
                write_reg(dir_tab[k].cfg_idx, dir_tab[k].cfg_val);
            end else begin
                send_packet(dir_tab[k].arr, dir_tab[k].pher, dir_tab[k].dx, dir_tab[k].dy,
                            dir_tab[k].draw, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        // random phases: corner nodes with extreme gains, then random settings
        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_routes();
            case (p)
                0:       begin nx = 4'd0; ny = 4'd0; ng = 4'd15; end
                1:       begin nx = 4'd7; ny = 4'd7; ng = 4'd0;  end
                2:       begin nx = 4'd0; ny = 4'd7; ng = 4'd1;  end
                3:       begin nx = 4'd7; ny = 4'd0; ng = 4'd15; end
                default: begin
                    nx = 4'($urandom_range(0, 15));
                    ny = 4'($urandom_range(0, 15));
                    ng = 4'($urandom_range(0, 15));
                end
            endcase
            write_reg(CFG_GAIN, ng);
            write_reg(CFG_X, nx);
            write_reg(CFG_Y, ny);
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
            for (r = 0; r < PHASE_ITEMS; r++) begin
                arr = acmrs_pkg::t_dir'($urandom_range(0, 3));
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    ph = 9'($urandom_range(0, 256));
                else if (sel < 9)
                    ph = 9'($urandom_range(257, 511));
                else
                    ph = ($urandom_range(0, 1) == 1) ? 9'd511 : 9'd0;
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    draw = 16'h0000;
                else if (sel == 1)
                    draw = 16'hFFFF;
                else
                    draw = 16'($urandom_range(0, 65535));
                send_packet(arr, ph, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            draw, 1'b0, '{dir: NORTH, found: 1'b0});
            end
        end

        // let the last routes out, then watch for strays
        drain_routes();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d packets and %0d register writes over corner and random nodes",
                 items_sent, cfg_writes);
        $display("%0d routes compared, %0d mismatches", routes_seen, errors);
        if (errors == 0 && route_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
